// File: rtl/core/pmalu_pkg.sv
// ----------------------------------------------------------------------------
// Prime-field ALU package
// Shared constants, operation codes and datapath types for the arithmetic
// unit over the field of integers modulo 1000000007.
// ----------------------------------------------------------------------------
package pmalu_pkg;

	// Field element width and the prime modulus.
	localparam int unsigned ELEM_W    = 30;
	localparam int unsigned WIDE_W    = 64;
	localparam logic [ELEM_W-1:0] MODULUS = 30'd1000000007;

	// Step counts of the bit-serial loops and the width of their counter.
	localparam int unsigned MUL_STEPS = ELEM_W;
	localparam int unsigned RED_STEPS = WIDE_W;
	localparam int unsigned CNT_W     = 6;

	// Operation codes carried in the input tuser field.
	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_NEG = 3'd4;
	localparam logic [2:0] KIND_INV = 3'd5;
	localparam logic [2:0] KIND_RED = 3'd6;

	typedef logic [ELEM_W-1:0] elem_t;

	// Working registers of the binary extended Euclid inverse.
	typedef struct packed {
		elem_t u;
		elem_t v;
		elem_t x1;
		elem_t x2;
	} inv_state_t;

endpackage

// File: rtl/core/pmalu_dbl_add.sv
// ----------------------------------------------------------------------------
// Modular double-and-add unit
// Computes (2 * acc + addend) mod MODULUS for acc and addend already reduced.
// Shared by the bit-serial multiply and the wide-value reduction.
// ----------------------------------------------------------------------------
module pmalu_dbl_add (
	input  pmalu_pkg::elem_t acc,
	input  pmalu_pkg::elem_t addend,
	output pmalu_pkg::elem_t sum
);
	import pmalu_pkg::*;

	localparam logic [ELEM_W+1:0] MOD_X = {2'b00, MODULUS};

	logic [ELEM_W+1:0] raw;
	logic [ELEM_W+1:0] once;
	logic [ELEM_W+1:0] twice;

	// The raw value stays below three times the modulus, so two conditional
	// subtractions bring it back into range.
	always_comb begin
		raw   = {1'b0, acc, 1'b0} + {2'b00, addend};
		once  = (raw >= MOD_X) ? raw - MOD_X : raw;
		twice = (once >= MOD_X) ? once - MOD_X : once;
	end

	assign sum = twice[ELEM_W-1:0];

endmodule

// File: rtl/core/pmalu_inv_step.sv
// ----------------------------------------------------------------------------
// Binary inverse step
// One iteration of the binary extended Euclidean algorithm modulo the prime:
// halve an even u or v, or subtract the smaller from the larger.
// ----------------------------------------------------------------------------
module pmalu_inv_step (
	input  pmalu_pkg::inv_state_t cur,
	output pmalu_pkg::inv_state_t nxt
);
	import pmalu_pkg::*;

	// Halve a field element: add the odd modulus first when it is odd.
	function automatic elem_t halve(input elem_t x);
		logic [ELEM_W:0] s;
		s = x[0] ? ({1'b0, x} + {1'b0, MODULUS}) : {1'b0, x};
		return s[ELEM_W:1];
	endfunction

	// Modular subtraction of two reduced elements; wraps back when negative.
	function automatic elem_t sub_mod(input elem_t a, input elem_t b);
		elem_t corr;
		corr = (a < b) ? MODULUS : '0;
		return a - b + corr;
	endfunction

	// Invariants: x1 * val == u and x2 * val == v modulo the prime.
	always_comb begin
		nxt = cur;
		priority if (!cur.u[0]) begin
			nxt.u  = cur.u >> 1;
			nxt.x1 = halve(cur.x1);
		end else if (!cur.v[0]) begin
			nxt.v  = cur.v >> 1;
			nxt.x2 = halve(cur.x2);
		end else if (cur.u >= cur.v) begin
			nxt.u  = cur.u - cur.v;
			nxt.x1 = sub_mod(cur.x1, cur.x2);
		end else begin
			nxt.v  = cur.v - cur.u;
			nxt.x2 = sub_mod(cur.x2, cur.x1);
		end
	end

endmodule

// File: rtl/core/prime_modular_alu.sv
// Add, subtract, negate and unused codes take a single operation step; multiply
// runs the bit-serial double-and-add loop, wide reduction that loop and the sign
// fix, inverse the binary Euclid iterations, and divide those plus a multiply.
// One item is in work at a time; the next is taken once the result is in the
// output register, which may still wait for its transfer.
// Reset (arst_n low, asynchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
// Prime-field arithmetic unit
// Add, subtract, multiply, divide, negate, inverse and signed 64-bit
// reduction modulo 1000000007, built around a shared double-and-add unit and
// a binary inverse step under one sequencer.
// ----------------------------------------------------------------------------
module prime_modular_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: left_operand[29:0], right_operand[59:30], wide_value[123:60], zero pad
	input  logic [127:0] s_tdata,
	// tuser: kind[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: result[29:0], zero pad
	output logic [31:0]  m_tdata
);
	import pmalu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPS,
		ST_INV,
		ST_MUL,
		ST_RED,
		ST_FIN
	} state_t;

	localparam int unsigned PAD_W = WIDE_W - ELEM_W;

	state_t             state_q;
	logic [2:0]         kind_q;
	elem_t              x_q;
	elem_t              y_q;
	elem_t              acc_q;
	elem_t              res_q;
	logic [WIDE_W-1:0]  mag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               m_tvalid_q;
	inv_state_t         inv_q;
	inv_state_t         inv_next;

	elem_t              in_x;
	elem_t              in_y;
	logic [WIDE_W-1:0]  in_wide;
	logic [WIDE_W-1:0]  in_mag;
	elem_t              addend;
	elem_t              dbl_sum;
	elem_t              ops_val;
	elem_t              inv_res;
	logic               inv_done;
	logic [ELEM_W:0]    add_raw;
	logic               in_xfer;
	logic               out_load;

	// Operand folding and magnitude of the wide value at the input transfer.
	always_comb begin
		in_x    = (s_tdata[29:0] >= MODULUS) ? s_tdata[29:0] - MODULUS : s_tdata[29:0];
		in_y    = (s_tdata[59:30] >= MODULUS) ? s_tdata[59:30] - MODULUS : s_tdata[59:30];
		in_wide = s_tdata[123:60];
		in_mag  = in_wide[WIDE_W-1] ? (~in_wide + 1'b1) : in_wide;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// A finished result moves to the output register once that register is free.
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Shared double-and-add: multiplier bits for multiply, value bits for
	// wide reduction.
	always_comb begin
		if (state_q == ST_MUL) begin
			addend = mag_q[WIDE_W-1] ? x_q : '0;
		end else begin
			addend = {{(ELEM_W-1){1'b0}}, mag_q[WIDE_W-1]};
		end
	end

	pmalu_dbl_add u_dbl_add (
		.acc    (acc_q),
		.addend (addend),
		.sum    (dbl_sum)
	);

	pmalu_inv_step u_inv_step (
		.cur (inv_q),
		.nxt (inv_next)
	);

	// The inverse is found when either u or v reaches one.
	always_comb begin
		inv_done = (inv_q.u == ELEM_W'(1)) || (inv_q.v == ELEM_W'(1));
		inv_res  = (inv_q.u == ELEM_W'(1)) ? inv_q.x1 : inv_q.x2;
	end

	// Single-step operations, and the sign fix after wide reduction.
	always_comb begin
		add_raw = {1'b0, x_q} + {1'b0, y_q};
		unique case (kind_q)
			KIND_ADD: ops_val = (add_raw >= {1'b0, MODULUS}) ?
				ELEM_W'(add_raw - {1'b0, MODULUS}) : add_raw[ELEM_W-1:0];
			KIND_SUB: ops_val = x_q - y_q + ((x_q < y_q) ? MODULUS : '0);
			KIND_NEG: ops_val = (x_q == '0) ? '0 : MODULUS - x_q;
			KIND_RED: ops_val = (neg_q && acc_q != '0) ? MODULUS - acc_q : acc_q;
			default:  ops_val = '0;
		endcase
	end

	// Sequencer with its working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			kind_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			acc_q      <= '0;
			res_q      <= '0;
			mag_q      <= '0;
			cnt_q      <= '0;
			neg_q      <= 1'b0;
			inv_q      <= '0;
		end else begin
			// Output valid: set by a new result, cleared once the result is taken.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q <= s_tuser;
						x_q    <= in_x;
						y_q    <= in_y;
						neg_q  <= in_wide[WIDE_W-1];
						acc_q  <= '0;
						priority if (s_tuser == KIND_MUL) begin
							mag_q   <= {in_y, {PAD_W{1'b0}}};
							cnt_q   <= CNT_W'(MUL_STEPS - 1);
							state_q <= ST_MUL;
						end else if (s_tuser == KIND_DIV) begin
							inv_q   <= '{u: in_y, v: MODULUS, x1: ELEM_W'(1), x2: '0};
							state_q <= (in_y == '0) ? ST_FIN : ST_INV;
						end else if (s_tuser == KIND_INV) begin
							inv_q   <= '{u: in_x, v: MODULUS, x1: ELEM_W'(1), x2: '0};
							state_q <= (in_x == '0) ? ST_FIN : ST_INV;
						end else if (s_tuser == KIND_RED) begin
							mag_q   <= in_mag;
							cnt_q   <= CNT_W'(RED_STEPS - 1);
							state_q <= ST_RED;
						end else begin
							state_q <= ST_OPS;
						end
					end
				end
				ST_INV: begin
					if (inv_done) begin
						if (kind_q == KIND_DIV) begin
							mag_q   <= {inv_res, {PAD_W{1'b0}}};
							cnt_q   <= CNT_W'(MUL_STEPS - 1);
							state_q <= ST_MUL;
						end else begin
							acc_q   <= inv_res;
							state_q <= ST_FIN;
						end
					end else begin
						inv_q <= inv_next;
					end
				end
				ST_MUL: begin
					acc_q <= dbl_sum;
					mag_q <= mag_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_RED: begin
					acc_q <= dbl_sum;
					mag_q <= mag_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_OPS;
					end
				end
				ST_OPS: begin
					acc_q   <= ops_val;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// Hand the result over once the output register is free.
					if (out_load) begin
						res_q   <= acc_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q};

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prime-field ALU testbench
// Drives add, subtract, multiply, divide, negate, inverse, wide-reduction and
// unused-code requests into the unit, predicts every result modulo 1000000007, and checks
// each result transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import pmalu_pkg::*;

	// Code with no operation behind it; the unit answers it with zero.
	localparam logic [2:0] KIND_NONE = 3'd7;

	localparam longint unsigned P_U    = 64'd1000000007;
	localparam longint          P_S    = 64'sd1000000007;
	localparam int unsigned     P_INT  = 32'd1000000007;
	localparam int unsigned     TOP_30 = 32'h3FFF_FFFF;

	localparam int RANDOM_OPS = 950;
	localparam int CALM_FIRST = 400;
	localparam int CALM_LAST  = 560;
	localparam int IDLE_PCT   = 19;
	localparam int DRAIN_CYC  = 200;
	localparam int CYCLE_CAP  = 800000;

	typedef struct {
		logic [2:0]         kind;
		elem_t              left;
		elem_t              right;
		logic signed [63:0] wide;
	} op_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;

	op_item_t op_queue[$];
	elem_t    due_results[$];
	op_item_t cur_item;
	bit       on_bus;
	int       sent_cnt;
	int       checked_cnt;
	int       fail_cnt;
	int       cycle_cnt;
	int       kind_seen[8];

	prime_modular_alu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Inverse by the extended Euclidean algorithm; zero maps to zero.
	function automatic longint unsigned inverse_of(longint unsigned val);
		longint a, b, u, v, q, t;
		a = val;
		b = P_S;
		u = 1;
		v = 0;
		while (b > 0) begin
			q = a / b;
			a = a - q * b;
			t = a; a = b; b = t;
			u = u - q * v;
			t = u; u = v; v = t;
		end
		u = u % P_S;
		if (u < 0) begin
			u = u + P_S;
		end
		return longint'(u);
	endfunction

	// Signed 64-bit value folded into 0..P-1, the most negative value included.
	function automatic longint unsigned fold_wide(logic [63:0] raw);
		longint unsigned mag, r;
		if (!raw[63]) begin
			return raw % P_U;
		end
		mag = ~raw + 64'd1;
		r   = mag % P_U;
		return (r == 0) ? 64'd0 : P_U - r;
	endfunction

	// Expected result of one request; operands are reduced first.
	function automatic elem_t field_result(op_item_t it);
		longint unsigned x, y, r;
		x = it.left % P_U;
		y = it.right % P_U;
		case (it.kind)
			KIND_ADD: begin
				r = x + y;
				if (r >= P_U) begin
					r = r - P_U;
				end
			end
			KIND_SUB: r = (x >= y) ? x - y : x + P_U - y;
			KIND_MUL: r = (x * y) % P_U;
			KIND_DIV: r = (x * inverse_of(y)) % P_U;
			KIND_NEG: r = (x == 0) ? 64'd0 : P_U - x;
			KIND_INV: r = inverse_of(x);
			KIND_RED: r = fold_wide(it.wide);
			default:  r = 0;
		endcase
		return elem_t'(r);
	endfunction

	task automatic queue_op(logic [2:0] kind, elem_t left, elem_t right, longint wide);
		op_item_t it;
		it.kind  = kind;
		it.left  = left;
		it.right = right;
		it.wide  = wide;
		op_queue.push_back(it);
	endtask

	// Operand mix: edges, unreduced values and ordinary field elements.
	function automatic elem_t pick_elem();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return elem_t'(1);
			2:       return elem_t'(P_INT - 1);
			3:       return elem_t'($urandom_range(TOP_30, P_INT));
			default: return elem_t'($urandom_range(P_INT - 1, 0));
		endcase
	endfunction

	function automatic longint pick_wide();
		longint k;
		case ($urandom_range(0, 5))
			0: return longint'($urandom_range(2000, 0)) - 1000;
			1: begin
				k = longint'($urandom_range(1 << 20, 0)) * P_S;
				return $urandom_range(1, 0) ? -k : k;
			end
			2: begin
				case ($urandom_range(0, 3))
					0:       return {1'b1, 63'd0};
					1:       return {1'b0, {63{1'b1}}};
					2:       return -64'sd1;
					default: return {1'b1, 63'd0} + longint'($urandom_range(99, 0));
				endcase
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Request driver: a new item goes out at the falling edge once the last
	// one has been transferred, with random idle cycles outside the calm window.
	always @(negedge clk) begin
		if (arst_n && !on_bus) begin
			if (op_queue.size() == 0 ||
			    (!(sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) &&
			     $urandom_range(99, 0) < IDLE_PCT)) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_item = op_queue.pop_front();
				on_bus   = 1'b1;
				s_tvalid <= 1'b1;
				s_tuser  <= cur_item.kind;
				s_tdata  <= {4'b0, cur_item.wide, cur_item.right, cur_item.left};
			end
		end
	end

	// Result back-pressure.
	always @(negedge clk) begin
		if (arst_n) begin
			if (checked_cnt >= CALM_FIRST && checked_cnt < CALM_LAST) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	// Monitor: check result transfers, then record accepted requests.
	always @(posedge clk) begin
		elem_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					fail_cnt++;
					$display("%0t: result 0x%08h with no request outstanding", $time, m_tdata);
				end else begin
					want = due_results.pop_front();
					checked_cnt++;
					if (m_tdata[ELEM_W-1:0] !== want || m_tdata[31:ELEM_W] !== '0) begin
						fail_cnt++;
						$display("%0t: result mismatch, expected %0d, actual %0d (word 0x%08h)",
							$time, want, m_tdata[ELEM_W-1:0], m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due_results.push_back(field_result(cur_item));
				kind_seen[cur_item.kind]++;
				sent_cnt++;
				on_bus = 1'b0;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				due_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;

		// Directed: field extremes, unreduced operands, zero cases, every code.
		queue_op(KIND_ADD, elem_t'(P_INT - 1), elem_t'(P_INT - 1), 0);
		queue_op(KIND_ADD, elem_t'(TOP_30), elem_t'(TOP_30), -1);
		queue_op(KIND_ADD, '0, '0, 0);
		queue_op(KIND_SUB, '0, elem_t'(P_INT - 1), 0);
		queue_op(KIND_SUB, elem_t'(12345), elem_t'(12345), 0);
		queue_op(KIND_SUB, elem_t'(P_INT), elem_t'(TOP_30), 0);
		queue_op(KIND_MUL, elem_t'(P_INT - 1), elem_t'(P_INT - 1), 0);
		queue_op(KIND_MUL, elem_t'(TOP_30), elem_t'(TOP_30), 0);
		queue_op(KIND_MUL, '0, elem_t'(P_INT - 1), 0);
		queue_op(KIND_DIV, elem_t'(777), '0, 0);
		queue_op(KIND_DIV, elem_t'(777), elem_t'(P_INT), 0);
		queue_op(KIND_DIV, elem_t'(P_INT - 1), elem_t'(P_INT - 1), 0);
		queue_op(KIND_DIV, elem_t'(TOP_30), elem_t'(2), 0);
		queue_op(KIND_NEG, '0, '0, 0);
		queue_op(KIND_NEG, elem_t'(P_INT), '0, 0);
		queue_op(KIND_NEG, elem_t'(P_INT - 1), '0, 0);
		queue_op(KIND_INV, '0, elem_t'(TOP_30), 0);
		queue_op(KIND_INV, elem_t'(1), '0, 0);
		queue_op(KIND_INV, elem_t'(P_INT - 1), '0, 0);
		queue_op(KIND_INV, elem_t'(TOP_30), '0, 0);
		queue_op(KIND_RED, '0, '0, {1'b1, 63'd0});
		queue_op(KIND_RED, '0, '0, {1'b0, {63{1'b1}}});
		queue_op(KIND_RED, '0, '0, -64'sd1);
		queue_op(KIND_RED, '0, '0, -P_S);
		queue_op(KIND_RED, elem_t'(TOP_30), elem_t'(TOP_30), P_S);
		queue_op(KIND_NONE, elem_t'(TOP_30), elem_t'(TOP_30), -64'sd1);

		// Random requests; every field is randomized whether used or not.
		repeat (RANDOM_OPS) begin
			queue_op(3'($urandom_range(7, 0)), pick_elem(), pick_elem(), pick_wide());
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || on_bus || due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d requests, checked %0d results, %0d failures.",
			sent_cnt, checked_cnt, fail_cnt);
		$display("Per code: add %0d sub %0d mul %0d div %0d neg %0d inv %0d red %0d none %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
			kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
		if (fail_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
